/* rtl/acme_pkg.sv */
// types and constants shared by the cursor move encoder
package acme_pkg;

   localparam int OFFSET_WIDTH = 17;
   localparam int MAG_DIGITS   = 5;
   localparam int BCD_WIDTH    = 4 * MAG_DIGITS;

   typedef logic [7:0]              byte_type;
   typedef logic [3:0]              digit_type;
   typedef logic [BCD_WIDTH-1:0]    bcd_type;
   typedef logic [OFFSET_WIDTH-1:0] mag_type;

   localparam byte_type ESC_BYTE      = 8'h1B;
   localparam byte_type LBRACKET_BYTE = 8'h5B;
   localparam byte_type SUFFIX_UP     = 8'h41;
   localparam byte_type SUFFIX_DOWN   = 8'h42;
   localparam byte_type DIGIT_ZERO    = 8'h30;

endpackage

/* rtl/ansi_cursor_move_encoder.sv */
// cursor up/down escape sequence encoder with bit-serial binary to bcd conversion
//
// A transaction is accepted on the rising edge where start is high and busy is low;
// req_offset carries the signed row offset. A positive offset gives ESC [ n A, a
// negative one ESC [ n B, where n is the magnitude in decimal without leading zeros.
// A zero offset is accepted and produces nothing; busy stays low.
// Each byte appears on rsp_out_byte for exactly one cycle with rsp_strobe high;
// rsp_last marks the suffix byte. The receiver cannot stall, so bytes are never held.
// A non-zero offset keeps busy high through the shift-and-add-three loop (one
// magnitude bit per cycle), the leading-zero skip and the emitted bytes. The first
// byte strobes after the conversion and the leading-zero skip, the rest follow back to
// back. A new offset may be accepted on the cycle the last byte is strobed.
// Reset (synchronous, active high) returns to idle and clears the strobe.
// Magnitudes above MAX_DIGITS nines are clamped to that value.
module ansi_cursor_move_encoder
   import acme_pkg::*;
#(
   parameter int MAX_DIGITS = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [OFFSET_WIDTH-1:0] req_offset,
   output logic                           rsp_strobe,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last
);

   function automatic logic [31:0] calc_limit(input int digits);
      logic [31:0] p;
      p = 32'd1;
      for (int i = 0; i < digits; i++) begin
         p = p * 32'd10;
      end
      return p - 32'd1;
   endfunction

   localparam logic [31:0] MAG_LIMIT = calc_limit(MAX_DIGITS);
   localparam int BIT_CNT_W = $clog2(OFFSET_WIDTH);
   localparam int DIG_CNT_W = $clog2(MAG_DIGITS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CONV   = 3'd1;
   localparam logic [2:0] ST_SKIP   = 3'd2;
   localparam logic [2:0] ST_ESC    = 3'd3;
   localparam logic [2:0] ST_BRKT   = 3'd4;
   localparam logic [2:0] ST_DIGIT  = 3'd5;
   localparam logic [2:0] ST_SUFFIX = 3'd6;

   logic [2:0]           state_ff, state_in;
   mag_type              mag_ff, mag_in;
   bcd_type              bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0] dig_cnt_ff, dig_cnt_in;
   logic                 neg_ff, neg_in;
   logic                 strobe_ff, strobe_in;
   byte_type             byte_ff, byte_in;
   logic                 last_ff, last_in;

   mag_type   raw_mag;
   mag_type   clamp_mag;
   bcd_type   bcd_adj;
   digit_type top_digit;

   assign raw_mag   = req_offset[OFFSET_WIDTH-1] ? mag_type'(-req_offset)
                                                 : mag_type'(req_offset);
   assign clamp_mag = ({{(32 - OFFSET_WIDTH){1'b0}}, raw_mag} > MAG_LIMIT)
                      ? MAG_LIMIT[OFFSET_WIDTH-1:0] : raw_mag;
   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < MAG_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                        : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      neg_in     = neg_ff;
      strobe_in  = 1'b0;
      byte_in    = byte_ff;
      last_in    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_offset != '0)) begin
               state_in   = ST_CONV;
               mag_in     = clamp_mag;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(OFFSET_WIDTH - 1);
               dig_cnt_in = DIG_CNT_W'(MAG_DIGITS);
               neg_in     = req_offset[OFFSET_WIDTH-1];
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_WIDTH-2:0], mag_ff[OFFSET_WIDTH-1]};
            mag_in = {mag_ff[OFFSET_WIDTH-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = ST_SKIP;
            end else begin
               bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            end
         end
         ST_SKIP: begin
            if (top_digit == '0) begin
               bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'h0};
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end else begin
               state_in = ST_ESC;
            end
         end
         ST_ESC: begin
            strobe_in = 1'b1;
            byte_in   = ESC_BYTE;
            state_in  = ST_BRKT;
         end
         ST_BRKT: begin
            strobe_in = 1'b1;
            byte_in   = LBRACKET_BYTE;
            state_in  = ST_DIGIT;
         end
         ST_DIGIT: begin
            strobe_in  = 1'b1;
            byte_in    = DIGIT_ZERO | {4'h0, top_digit};
            bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'h0};
            dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            if (dig_cnt_ff == DIG_CNT_W'(1)) begin
               state_in = ST_SUFFIX;
            end
         end
         ST_SUFFIX: begin
            strobe_in = 1'b1;
            byte_in   = neg_ff ? SUFFIX_DOWN : SUFFIX_UP;
            last_in   = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      neg_ff     <= neg_in;
      byte_ff    <= byte_in;
      last_ff    <= last_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the cursor up/down escape sequence encoder
`timescale 1ns / 1ps

module tb_top;
   import acme_pkg::*;

   localparam int MAX_DIGITS = 5;

   typedef logic signed [OFFSET_WIDTH-1:0] offset_type;

   typedef struct {
      byte_type code;
      logic     last;
   } seq_byte_type;

   class cursor_seq_scoreboard;
      seq_byte_type expected_bytes[$];
      int           mismatches;
      int           magnitude_limit;

      function new(int digits);
         magnitude_limit = 1;
         repeat (digits) magnitude_limit *= 10;
         magnitude_limit -= 1;
         mismatches = 0;
      endfunction

      function void note_offset(offset_type offset);
         int           mag;
         byte_type     digit_codes[$];
         seq_byte_type item;
         mag = int'(offset);
         if (mag == 0) return;
         if (mag < 0) mag = -mag;
         if (mag > magnitude_limit) mag = magnitude_limit;
         while (mag > 0) begin
            digit_codes.push_front(DIGIT_ZERO + byte_type'(mag % 10));
            mag = mag / 10;
         end
         item.last = 1'b0;
         item.code = ESC_BYTE;
         expected_bytes.push_back(item);
         item.code = LBRACKET_BYTE;
         expected_bytes.push_back(item);
         foreach (digit_codes[i]) begin
            item.code = digit_codes[i];
            expected_bytes.push_back(item);
         end
         item.code = offset[OFFSET_WIDTH-1] ? SUFFIX_DOWN : SUFFIX_UP;
         item.last = 1'b1;
         expected_bytes.push_back(item);
      endfunction

      function void check_byte(byte_type code, logic last);
         seq_byte_type want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %h last %b", code, last);
            return;
         end
         want = expected_bytes.pop_front();
         if (code !== want.code || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("byte mismatch: expected %h last %b, got %h last %b",
                        want.code, want.last, code, last);
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   offset_type req_offset;
   logic       rsp_strobe;
   byte_type   rsp_out_byte;
   logic       rsp_last;

   cursor_seq_scoreboard seq_board = new(MAX_DIGITS);

   ansi_cursor_move_encoder #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_offset   (req_offset),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) seq_board.check_byte(rsp_out_byte, rsp_last);
         if (start && !busy) seq_board.note_offset(req_offset);
      end
   end

   task automatic send_offset(offset_type value, int idle_pct, bit drain);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct && gap < 60) gap++;
      if (drain && gap == 0) gap = 1;
      if (gap > 0) begin
         start <= 1'b0;
         if (drain) begin
            while (seq_board.pending() != 0) @(posedge clock);
         end
         repeat (gap) @(posedge clock);
      end
      start      <= 1'b1;
      req_offset <= value;
      do @(posedge clock); while (busy);
   endtask

   function automatic offset_type random_offset();
      int pick;
      int digits;
      int low;
      int high;
      int mag;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick <= 2) return offset_type'($urandom());
      digits = $urandom_range(1, MAX_DIGITS);
      low = 1;
      repeat (digits - 1) low *= 10;
      high = low * 10 - 1;
      if (high > 65535) high = 65535;
      mag = $urandom_range(low, high);
      return $urandom_range(0, 1) ? offset_type'(-mag) : offset_type'(mag);
   endfunction

   int directed_offsets[] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, -999, 1000, 9999, -10000, 65535,
      -65535, -65536, 0, 0, 12345, -54321, 43690, -43691, 21845, 0, 7
   };
   int phase_idle[3]  = '{31, 80, 0};
   int phase_items[3] = '{160, 160, 150};

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_offset = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_offsets[i])
         send_offset(offset_type'(directed_offsets[i]), phase_idle[0], i == 16);

      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < phase_items[phase]; i++)
            send_offset(random_offset(), phase_idle[phase], i % 50 == 25);
      end

      start <= 1'b0;
      while (seq_board.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (seq_board.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
